// File: sv/okl_pkg.sv
// -----------------------------------------------------------------------------
// okl_pkg - shared types and constants of the OKLCH to sRGB converter
// Holds the root unit request/response structs and the default attempt count.
// -----------------------------------------------------------------------------
package okl_pkg;

    localparam int MAX_ATTEMPTS_DEF = 24;

    localparam int ROOT_ARG_W = 63;
    localparam int ROOT_W     = 30;

    typedef struct packed {
        logic                  start;
        logic                  cube;
        logic [ROOT_ARG_W-1:0] arg;
    } root_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } root_rsp_t;

endpackage

// File: sv/okl_root_unit.sv
// -----------------------------------------------------------------------------
// okl_root_unit - bit-serial integer cube root and square root
// Restoring digit recurrence: three operand bits per step for a cube root
// (21 steps), two bits per step for a square root (30 steps).
// -----------------------------------------------------------------------------
module okl_root_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  okl_pkg::root_req_t req,
    output okl_pkg::root_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        cube_reg, cube_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [62:0] op_reg, op_next;
    logic [29:0] y_reg, y_next;
    logic [43:0] ysq_reg, ysq_next;
    logic [47:0] rem_reg, rem_next;

    logic [29:0] y2;
    logic [43:0] y2sq;
    logic [45:0] csum;
    logic [47:0] rem_sh, trial;
    logic        ge;

    // Form the shifted remainder and the trial subtrahend of one step
    always_comb
    begin
        y2   = {y_reg[28:0], 1'b0};
        y2sq = {ysq_reg[41:0], 2'b00};
        csum = 46'(y2sq) + 46'(y2);
        if (cube_reg)
        begin
            rem_sh = {rem_reg[44:0], op_reg[62:60]};
            trial  = 48'(csum) + 48'({csum, 1'b0}) + 48'd1;
        end
        else
        begin
            rem_sh = {rem_reg[45:0], op_reg[62:61]};
            trial  = 48'({y_reg, 2'b01});
        end
        ge = (rem_sh >= trial);
    end

    // Load on start, then advance one digit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cube_next = cube_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        y_next    = y_reg;
        ysq_next  = ysq_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cube_next = req.cube;
            cnt_next  = req.cube ? 5'd20 : 5'd29;
            op_next   = req.cube ? req.arg : {req.arg[59:0], 3'b000};
            y_next    = '0;
            ysq_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_sh - trial) : rem_sh;
            y_next   = {y_reg[28:0], ge};
            ysq_next = ge ? (y2sq + 44'({y2, 1'b0}) + 44'd1) : y2sq;
            op_next  = cube_reg ? {op_reg[59:0], 3'b000} : {op_reg[60:0], 2'b00};
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cube_reg <= cube_next;
        op_reg   <= op_next;
        y_reg    <= y_next;
        ysq_reg  <= ysq_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = y_reg;

endmodule

// File: sv/oklch_to_srgb8_gamut_reduce.sv
// -----------------------------------------------------------------------------
// oklch_to_srgb8_gamut_reduce - OKLCH colour to 8-bit sRGB with chroma reduction
// From input transfer to m_axis_tvalid: sine and cosine, then up to 24 gamut
// attempts (the default), with a chroma reduction after each failed one but the
// last, on the shared 33x33 multiplier, then per channel the linear segment or
// the gamma curve, which uses the bit-serial root unit (21 + 30 + 30 steps), and
// a finish step. One item at a time; the next is taken in the cycle after the
// result enters the output register. Reset clears control state asynchronously.
// -----------------------------------------------------------------------------
module oklch_to_srgb8_gamut_reduce #(
    parameter int MAX_ATTEMPTS = okl_pkg::MAX_ATTEMPTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // lightness[16:0], chroma[32:17], hue_turns[48:33], opacity[56:49], zero pad
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], opacity_out[31:24]
    output logic [31:0] m_axis_tdata
);

    localparam int AW = (MAX_ATTEMPTS > 1) ? $clog2(MAX_ATTEMPTS) : 1;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_SINE   = 5'b00010,
        PH_TRIAL  = 5'b00100,
        PH_ENCODE = 5'b01000,
        PH_FINISH = 5'b10000
    } phase_t;

    // Encode sequencer steps
    localparam logic [4:0] EN_START = 5'd0;
    localparam logic [4:0] EN_SMALL = 5'd1;
    localparam logic [4:0] EN_CBRT  = 5'd2;
    localparam logic [4:0] EN_XCHI  = 5'd3;
    localparam logic [4:0] EN_XCLO  = 5'd4;
    localparam logic [4:0] EN_SQ1   = 5'd5;
    localparam logic [4:0] EN_SQ2   = 5'd6;
    localparam logic [4:0] EN_SCALE = 5'd7;
    localparam logic [4:0] EN_OFS   = 5'd8;
    localparam logic [4:0] EN_DIV   = 5'd9;
    localparam logic [4:0] EN_LDIV  = 5'd10;

    localparam logic signed [32:0] SIN_C0 = 33'sd172270;
    localparam logic signed [32:0] SIN_C1 = -33'sd5026995;
    localparam logic signed [32:0] SIN_C2 = 33'sd85569306;
    localparam logic signed [32:0] SIN_C3 = -33'sd693598669;
    localparam logic signed [32:0] SIN_C4 = 33'sd1686629713;

    localparam logic signed [32:0] K_LA = 33'sd25974;
    localparam logic signed [32:0] K_LB = 33'sd14143;
    localparam logic signed [32:0] K_MA = 33'sd6918;
    localparam logic signed [32:0] K_MB = 33'sd4185;
    localparam logic signed [32:0] K_SA = 33'sd5864;
    localparam logic signed [32:0] K_SB = 33'sd84639;

    localparam logic signed [32:0] M_RL = 33'sd267173;
    localparam logic signed [32:0] M_RM = -33'sd216774;
    localparam logic signed [32:0] M_RS = 33'sd15137;
    localparam logic signed [32:0] M_GL = -33'sd83128;
    localparam logic signed [32:0] M_GM = 33'sd171033;
    localparam logic signed [32:0] M_GS = -33'sd22369;
    localparam logic signed [32:0] M_BL = -33'sd275;
    localparam logic signed [32:0] M_BM = -33'sd46099;
    localparam logic signed [32:0] M_BS = 33'sd111910;

    localparam logic signed [32:0] K_CHROMA = 33'sd58982;
    localparam logic signed [32:0] K_LIN    = 33'sd32946;
    localparam logic signed [32:0] K_GAMMA  = 33'sd269025;
    localparam logic signed [65:0] LIN_OFS  = 66'sd327680;
    localparam logic signed [65:0] GAM_OFS  = 66'sd13525 <<< 28;
    localparam logic [16:0]        LIN_MAX  = 17'd205;
    // Reciprocals: ceil(2^43 / 655360) and ceil(2^28 / 1000)
    localparam logic signed [32:0] K_RLIN   = 33'sd13421773;
    localparam logic signed [32:0] K_RGAM   = 33'sd268436;

    phase_t              phase_reg, phase_next;
    logic [4:0]          pc_reg, pc_next;
    logic                sel_cos_reg, sel_cos_next;
    logic [AW-1:0]       attempt_reg, attempt_next;
    logic [1:0]          ch_reg, ch_next;
    logic                m_valid_reg, m_valid_next;
    logic [31:0]         m_data_reg, m_data_next;

    logic [16:0]         lig_reg, lig_next;
    logic [15:0]         chr_reg, chr_next;
    logic [15:0]         hue_reg, hue_next;
    logic [7:0]          opa_reg, opa_next;
    logic signed [17:0]  sn_reg, sn_next;
    logic signed [17:0]  cs_reg, cs_next;
    logic signed [32:0]  z2_reg, z2_next;
    logic signed [65:0]  prod_reg, prod_next;
    logic signed [65:0]  acc_reg, acc_next;
    logic signed [17:0]  a_reg, a_next;
    logic signed [17:0]  b_reg, b_next;
    logic signed [19:0]  lp_reg, lp_next;
    logic signed [19:0]  mp_reg, mp_next;
    logic signed [19:0]  sp_reg, sp_next;
    logic signed [22:0]  lc_reg, lc_next;
    logic signed [22:0]  mc_reg, mc_next;
    logic signed [22:0]  sc_reg, sc_next;
    logic signed [25:0]  lin_reg [3];
    logic signed [25:0]  lin_next [3];
    logic [7:0]          res_reg [3];
    logic [7:0]          res_next [3];
    logic [16:0]         x_reg, x_next;
    logic [20:0]         c_reg, c_next;
    logic [37:0]         xc_reg, xc_next;

    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  p30, s14, sum_full, sum_r16, prod_r16, sm_num, big_diff;
    logic [15:0]         hh;
    logic [14:0]         z;
    logic signed [32:0]  zq;
    logic [16:0]         sclamp;
    logic signed [17:0]  sval;
    logic signed [25:0]  bval, lin_sel;
    logic [16:0]         xcl;
    logic                gamut_ok;

    okl_pkg::root_req_t  root_req;
    okl_pkg::root_rsp_t  root_rsp;

    okl_root_unit u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (root_req),
        .rsp   (root_rsp)
    );

    function automatic logic in_gamut(input logic signed [25:0] v);
        return (v >= 26'sd0) && (v <= 26'sd65536);
    endfunction

    // Shared datapath terms around the product register
    always_comb
    begin
        hh       = sel_cos_reg ? (hue_reg + 16'd16384) : hue_reg;
        z        = hh[14] ? (15'd16384 - {1'b0, hh[13:0]}) : {1'b0, hh[13:0]};
        zq       = {2'b00, z, 16'h0000};
        p30      = prod_reg >>> 30;
        s14      = (p30 + 66'sd8192) >>> 14;
        if (s14 < 66'sd0)
            sclamp = 17'd0;
        else if (s14 > 66'sd65536)
            sclamp = 17'd65536;
        else
            sclamp = s14[16:0];
        sval     = hh[15] ? -$signed({1'b0, sclamp}) : $signed({1'b0, sclamp});
        sum_full = acc_reg + prod_reg;
        sum_r16  = (sum_full + 66'sd32768) >>> 16;
        prod_r16 = (prod_reg + 66'sd32768) >>> 16;
        sm_num   = prod_reg + LIN_OFS;
        big_diff = prod_reg - GAM_OFS;
        bval     = sum_r16[25:0];
        gamut_ok = in_gamut(lin_reg[0]) && in_gamut(lin_reg[1]) && in_gamut(bval);
        lin_sel  = lin_reg[ch_reg];
        if (lin_sel < 26'sd0)
            xcl = 17'd0;
        else if (lin_sel > 26'sd65536)
            xcl = 17'd65536;
        else
            xcl = lin_sel[16:0];
    end

    // Sequencer: operand selection for the shared multiplier and register updates
    always_comb
    begin
        phase_next   = phase_reg;
        pc_next      = pc_reg;
        sel_cos_next = sel_cos_reg;
        attempt_next = attempt_reg;
        ch_next      = ch_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        lig_next     = lig_reg;
        chr_next     = chr_reg;
        hue_next     = hue_reg;
        opa_next     = opa_reg;
        sn_next      = sn_reg;
        cs_next      = cs_reg;
        z2_next      = z2_reg;
        acc_next     = acc_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        lp_next      = lp_reg;
        mp_next      = mp_reg;
        sp_next      = sp_reg;
        lc_next      = lc_reg;
        mc_next      = mc_reg;
        sc_next      = sc_reg;
        lin_next     = lin_reg;
        res_next     = res_reg;
        x_next       = x_reg;
        c_next       = c_reg;
        xc_next      = xc_reg;
        mul_a        = '0;
        mul_b        = '0;
        root_req     = '0;

        // Drop the output once it transfers
        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    lig_next     = s_axis_tdata[16:0];
                    chr_next     = s_axis_tdata[32:17];
                    hue_next     = s_axis_tdata[48:33];
                    opa_next     = s_axis_tdata[56:49];
                    sel_cos_next = 1'b0;
                    attempt_next = '0;
                    pc_next      = 5'd0;
                    phase_next   = PH_SINE;
                end
            end

            // Horner odd polynomial, sine first then cosine
            PH_SINE:
            begin
                pc_next = pc_reg + 5'd1;
                case (pc_reg)
                    5'd0:
                    begin
                        mul_a = zq;
                        mul_b = zq;
                    end
                    5'd1:
                    begin
                        z2_next = p30[32:0];
                        mul_a   = SIN_C0;
                        mul_b   = p30[32:0];
                    end
                    5'd2:
                    begin
                        mul_a = SIN_C1 + p30[32:0];
                        mul_b = z2_reg;
                    end
                    5'd3:
                    begin
                        mul_a = SIN_C2 + p30[32:0];
                        mul_b = z2_reg;
                    end
                    5'd4:
                    begin
                        mul_a = SIN_C3 + p30[32:0];
                        mul_b = z2_reg;
                    end
                    5'd5:
                    begin
                        mul_a = SIN_C4 + p30[32:0];
                        mul_b = zq;
                    end
                    default:
                    begin
                        pc_next = 5'd0;
                        if (!sel_cos_reg)
                        begin
                            sn_next      = sval;
                            sel_cos_next = 1'b1;
                        end
                        else
                        begin
                            cs_next    = sval;
                            phase_next = PH_TRIAL;
                        end
                    end
                endcase
            end

            // One gamut attempt: a, b, LMS', cubes, matrix, check, and a chroma reduction on failure
            PH_TRIAL:
            begin
                pc_next = pc_reg + 5'd1;
                case (pc_reg)
                    5'd0:
                    begin
                        mul_a = {17'd0, chr_reg};
                        mul_b = 33'(cs_reg);
                    end
                    5'd1:
                    begin
                        a_next = prod_r16[17:0];
                        mul_a  = {17'd0, chr_reg};
                        mul_b  = 33'(sn_reg);
                    end
                    5'd2:
                    begin
                        b_next = prod_r16[17:0];
                        mul_a  = K_LA;
                        mul_b  = 33'(a_reg);
                    end
                    5'd3:
                    begin
                        acc_next = prod_reg;
                        mul_a    = K_LB;
                        mul_b    = 33'(b_reg);
                    end
                    5'd4:
                    begin
                        lp_next = {3'b000, lig_reg} + sum_r16[19:0];
                        mul_a   = K_MA;
                        mul_b   = 33'(a_reg);
                    end
                    5'd5:
                    begin
                        acc_next = prod_reg;
                        mul_a    = K_MB;
                        mul_b    = 33'(b_reg);
                    end
                    5'd6:
                    begin
                        mp_next = {3'b000, lig_reg} - sum_r16[19:0];
                        mul_a   = K_SA;
                        mul_b   = 33'(a_reg);
                    end
                    5'd7:
                    begin
                        acc_next = prod_reg;
                        mul_a    = K_SB;
                        mul_b    = 33'(b_reg);
                    end
                    5'd8:
                    begin
                        sp_next = {3'b000, lig_reg} - sum_r16[19:0];
                        mul_a   = 33'(lp_reg);
                        mul_b   = 33'(lp_reg);
                    end
                    5'd9:
                    begin
                        mul_a = prod_r16[32:0];
                        mul_b = 33'(lp_reg);
                    end
                    5'd10:
                    begin
                        lc_next = prod_r16[22:0];
                        mul_a   = 33'(mp_reg);
                        mul_b   = 33'(mp_reg);
                    end
                    5'd11:
                    begin
                        mul_a = prod_r16[32:0];
                        mul_b = 33'(mp_reg);
                    end
                    5'd12:
                    begin
                        mc_next = prod_r16[22:0];
                        mul_a   = 33'(sp_reg);
                        mul_b   = 33'(sp_reg);
                    end
                    5'd13:
                    begin
                        mul_a = prod_r16[32:0];
                        mul_b = 33'(sp_reg);
                    end
                    5'd14:
                    begin
                        sc_next = prod_r16[22:0];
                        mul_a   = M_RL;
                        mul_b   = 33'(lc_reg);
                    end
                    5'd15:
                    begin
                        acc_next = prod_reg;
                        mul_a    = M_RM;
                        mul_b    = 33'(mc_reg);
                    end
                    5'd16:
                    begin
                        acc_next = sum_full;
                        mul_a    = M_RS;
                        mul_b    = 33'(sc_reg);
                    end
                    5'd17:
                    begin
                        lin_next[0] = sum_r16[25:0];
                        mul_a       = M_GL;
                        mul_b       = 33'(lc_reg);
                    end
                    5'd18:
                    begin
                        acc_next = prod_reg;
                        mul_a    = M_GM;
                        mul_b    = 33'(mc_reg);
                    end
                    5'd19:
                    begin
                        acc_next = sum_full;
                        mul_a    = M_GS;
                        mul_b    = 33'(sc_reg);
                    end
                    5'd20:
                    begin
                        lin_next[1] = sum_r16[25:0];
                        mul_a       = M_BL;
                        mul_b       = 33'(lc_reg);
                    end
                    5'd21:
                    begin
                        acc_next = prod_reg;
                        mul_a    = M_BM;
                        mul_b    = 33'(mc_reg);
                    end
                    5'd22:
                    begin
                        acc_next = sum_full;
                        mul_a    = M_BS;
                        mul_b    = 33'(sc_reg);
                    end
                    5'd23:
                    begin
                        lin_next[2] = bval;
                        if (gamut_ok || (attempt_reg == AW'(MAX_ATTEMPTS - 1)))
                        begin
                            phase_next = PH_ENCODE;
                            pc_next    = EN_START;
                            ch_next    = 2'd0;
                        end
                        else
                        begin
                            mul_a = {17'd0, chr_reg};
                            mul_b = K_CHROMA;
                        end
                    end
                    default:
                    begin
                        chr_next     = prod_reg[31:16];
                        attempt_next = attempt_reg + AW'(1);
                        pc_next      = 5'd0;
                    end
                endcase
            end

            // Linear segment or gamma curve per channel
            PH_ENCODE:
            begin
                case (pc_reg)
                    EN_START:
                    begin
                        x_next = xcl;
                        if (xcl <= LIN_MAX)
                        begin
                            mul_a   = {16'd0, xcl};
                            mul_b   = K_LIN;
                            pc_next = EN_SMALL;
                        end
                        else
                        begin
                            root_req.start = 1'b1;
                            root_req.cube  = 1'b1;
                            root_req.arg   = {2'b00, xcl, 44'd0};
                            pc_next        = EN_CBRT;
                        end
                    end
                    // Divide by 655360 through the reciprocal
                    EN_SMALL:
                    begin
                        mul_a   = {10'd0, sm_num[22:0]};
                        mul_b   = K_RLIN;
                        pc_next = EN_LDIV;
                    end
                    EN_LDIV:
                    begin
                        res_next[ch_reg] = prod_reg[50:43];
                        pc_next          = EN_START;
                        if (ch_reg == 2'd2)
                            phase_next = PH_FINISH;
                        else
                            ch_next = ch_reg + 2'd1;
                    end
                    EN_CBRT:
                    begin
                        if (root_rsp.done)
                        begin
                            c_next  = root_rsp.root[20:0];
                            mul_a   = {16'd0, x_reg};
                            mul_b   = {12'd0, root_rsp.root[20:0]};
                            pc_next = EN_XCHI;
                        end
                    end
                    EN_XCHI:
                    begin
                        xc_next = prod_reg[37:0];
                        mul_a   = {14'd0, prod_reg[37:19]};
                        mul_b   = {12'd0, c_reg};
                        pc_next = EN_XCLO;
                    end
                    EN_XCLO:
                    begin
                        acc_next = prod_reg <<< 19;
                        mul_a    = {14'd0, xc_reg[18:0]};
                        mul_b    = {12'd0, c_reg};
                        pc_next  = EN_SQ1;
                    end
                    EN_SQ1:
                    begin
                        root_req.start = 1'b1;
                        root_req.arg   = {6'd0, sum_full[56:0]};
                        pc_next        = EN_SQ2;
                    end
                    EN_SQ2:
                    begin
                        if (root_rsp.done)
                        begin
                            root_req.start = 1'b1;
                            root_req.arg   = {5'd0, root_rsp.root, 28'd0};
                            pc_next        = EN_SCALE;
                        end
                    end
                    EN_SCALE:
                    begin
                        if (root_rsp.done)
                        begin
                            mul_a   = K_GAMMA;
                            mul_b   = {3'd0, root_rsp.root};
                            pc_next = EN_OFS;
                        end
                    end
                    EN_OFS:
                    begin
                        if (prod_reg <= GAM_OFS)
                        begin
                            res_next[ch_reg] = '0;
                            pc_next          = EN_START;
                            if (ch_reg == 2'd2)
                                phase_next = PH_FINISH;
                            else
                                ch_next = ch_reg + 2'd1;
                        end
                        else
                        begin
                            // Divide by 1000 through the reciprocal
                            mul_a   = {15'd0, big_diff[45:28]};
                            mul_b   = K_RGAM;
                            pc_next = EN_DIV;
                        end
                    end
                    EN_DIV:
                    begin
                        res_next[ch_reg] = prod_reg[35:28];
                        pc_next          = EN_START;
                        if (ch_reg == 2'd2)
                            phase_next = PH_FINISH;
                        else
                            ch_next = ch_reg + 2'd1;
                    end
                    default:
                    begin
                        pc_next = EN_START;
                    end
                endcase
            end

            // Hand the result to the output register once it is free
            PH_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {opa_reg, res_reg[2], res_reg[1], res_reg[0]};
                    phase_next   = PH_IDLE;
                end
            end

            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pc_reg      <= '0;
            sel_cos_reg <= 1'b0;
            attempt_reg <= '0;
            ch_reg      <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pc_reg      <= pc_next;
            sel_cos_reg <= sel_cos_next;
            attempt_reg <= attempt_next;
            ch_reg      <= ch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        lig_reg    <= lig_next;
        chr_reg    <= chr_next;
        hue_reg    <= hue_next;
        opa_reg    <= opa_next;
        sn_reg     <= sn_next;
        cs_reg     <= cs_next;
        z2_reg     <= z2_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        lp_reg     <= lp_next;
        mp_reg     <= mp_next;
        sp_reg     <= sp_next;
        lc_reg     <= lc_next;
        mc_reg     <= mc_next;
        sc_reg     <= sc_next;
        lin_reg    <= lin_next;
        res_reg    <= res_next;
        x_reg      <= x_next;
        c_reg      <= c_next;
        xc_reg     <= xc_next;
    end

    assign s_axis_tready = (phase_reg == PH_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Root unit is only started by the gamma sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        root_req.start |-> (phase_reg == PH_ENCODE))
        else $error("root unit started outside encode");

    // Attempt counter stays within the configured count
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TRIAL) |-> (attempt_reg <= AW'(MAX_ATTEMPTS - 1)))
        else $error("attempt counter overran");

    // A finished item reaches the output and frees the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_FINISH) && (!m_valid_reg || m_axis_tready))
        |=> (m_axis_tvalid && s_axis_tready))
        else $error("finished item not delivered");

    // An accepted item starts the sine sequence and closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> ((phase_reg == PH_SINE) && !s_axis_tready))
        else $error("accepted item did not start");

endmodule

// File: tb/tb.sv
// -----------------------------------------------------------------------------
// tb - self-checking bench for oklch_to_srgb8_gamut_reduce
// Drives OKLCH colours over the input stream, predicts each 8-bit sRGB result
// with a fixed-point model of the conversion and chroma reduction, and checks
// every output transfer in order under random idling on both sides.
// -----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [16:0] lightness;
        logic [15:0] chroma;
        logic [15:0] hue_turns;
        logic [7:0]  opacity;
    } colour_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity_out;
    } rgba_t;

    typedef struct {
        colour_t c;
        logic    known;
        rgba_t   px;
    } stim_row_t;

    localparam int N_RANDOM = 1080;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    rgba_t pixel_q[$];
    int    mismatches;
    bit    sending_done;

    oklch_to_srgb8_gamut_reduce i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Floor shift and round-half-up shift on signed values
    function automatic longint fl_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint rnd_shr(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // sin(pi/2 * z) for a Q14 position z, result Q16
    function automatic longint quad_sine(longint z);
        longint zq;
        longint z2;
        longint p;
        longint s;
        zq = z << 16;
        z2 = fl_shr(zq * zq, 30);
        p  = 172270;
        p  = -5026995 + fl_shr(p * z2, 30);
        p  = 85569306 + fl_shr(p * z2, 30);
        p  = -693598669 + fl_shr(p * z2, 30);
        p  = 1686629713 + fl_shr(p * z2, 30);
        s  = rnd_shr(fl_shr(p * zq, 30), 14);
        if (s < 0) s = 0;
        if (s > 65536) s = 65536;
        return s;
    endfunction

    function automatic longint hue_sine(logic [15:0] h);
        longint f;
        longint v;
        f = longint'(h[13:0]);
        v = h[14] ? quad_sine(16384 - f) : quad_sine(f);
        return h[15] ? -v : v;
    endfunction

    function automatic longint cube_q16(longint x);
        return rnd_shr(rnd_shr(x * x, 16) * x, 16);
    endfunction

    // Gamma-encode a linear channel to 8 bits
    function automatic logic [7:0] gamma8(longint v);
        longint unsigned x;
        longint unsigned c;
        longint unsigned t;
        longint unsigned p;
        longint unsigned r;
        longint unsigned y;
        longint unsigned num;
        longint unsigned off;
        longint unsigned q;
        if (v < 0) v = 0;
        if (v > 65536) v = 65536;
        x = v;
        if (x <= 205) return 8'((x * 32946 + 327680) / 655360);
        c = 0;
        for (int b = 20; b >= 0; b--)
        begin
            t = c | (64'd1 << b);
            if (t * t * t <= (x << 44)) c = t;
        end
        p = x * c * c;
        r = 0;
        for (int b = 29; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= p) r = t;
        end
        p = r << 28;
        y = 0;
        for (int b = 29; b >= 0; b--)
        begin
            t = y | (64'd1 << b);
            if (t * t <= p) y = t;
        end
        num = 269025 * y;
        off = 64'd13525 << 28;
        if (num <= off) return 8'd0;
        q = (num - off) / (64'd1000 << 28);
        return (q > 255) ? 8'd255 : 8'(q);
    endfunction

    // Convert one colour, reducing chroma until the result fits the gamut
    function automatic rgba_t oklch_to_rgba(colour_t c);
        longint lig;
        longint chr;
        longint sn;
        longint cs;
        longint a;
        longint b;
        longint l;
        longint m;
        longint s;
        longint lin[3];
        rgba_t  px;
        bit     fits;
        lig = longint'(c.lightness);
        chr = longint'(c.chroma);
        sn  = hue_sine(c.hue_turns);
        cs  = hue_sine(c.hue_turns + 16'd16384);
        for (int k = 0; k < okl_pkg::MAX_ATTEMPTS_DEF; k++)
        begin
            a = rnd_shr(chr * cs, 16);
            b = rnd_shr(chr * sn, 16);
            l = cube_q16(lig + rnd_shr(25974 * a + 14143 * b, 16));
            m = cube_q16(lig - rnd_shr(6918 * a + 4185 * b, 16));
            s = cube_q16(lig - rnd_shr(5864 * a + 84639 * b, 16));
            lin[0] = rnd_shr(267173 * l - 216774 * m + 15137 * s, 16);
            lin[1] = rnd_shr(-83128 * l + 171033 * m - 22369 * s, 16);
            lin[2] = rnd_shr(-275 * l - 46099 * m + 111910 * s, 16);
            fits = 1'b1;
            foreach (lin[i])
                if (lin[i] < 0 || lin[i] > 65536) fits = 1'b0;
            if (fits) break;
            chr = (chr * 58982) >>> 16;
        end
        px.red         = gamma8(lin[0]);
        px.green       = gamma8(lin[1]);
        px.blue        = gamma8(lin[2]);
        px.opacity_out = c.opacity;
        return px;
    endfunction

    // Send one colour, queue its prediction (or the typed-in one)
    task automatic send_colour(colour_t c, logic known, rgba_t px);
        int idle;
        idle = $urandom_range(0, 14);
        if (idle > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, c.opacity, c.hue_turns, c.chroma, c.lightness};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pixel_q.push_back(known ? px : oklch_to_rgba(c));
    endtask

    function automatic colour_t rand_colour();
        colour_t c;
        case ($urandom_range(0, 3))
            0: c.lightness = 17'($urandom_range(0, 131071));
            default: c.lightness = 17'($urandom_range(0, 65536));
        endcase
        c.chroma    = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 32768))
                                                 : 16'($urandom);
        c.hue_turns = 16'($urandom);
        c.opacity   = 8'($urandom);
        return c;
    endfunction

    // Stimulus: directed table, then random colours
    initial
    begin
        stim_row_t rows[$];
        rgba_t     none;
        colour_t   c;
        none = '0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        sending_done  = 1'b0;
        // black, white, lightness above one, chroma extremes, hue quadrants
        rows.push_back('{'{17'd0, 16'd0, 16'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0}});
        rows.push_back('{'{17'd65536, 16'd0, 16'd0, 8'd255}, 1'b1,
                         '{8'd255, 8'd255, 8'd255, 8'd255}});
        rows.push_back('{'{17'd131071, 16'd0, 16'hFFFF, 8'h5A}, 1'b1,
                         '{8'd255, 8'd255, 8'd255, 8'h5A}});
        rows.push_back('{'{17'd0, 16'hFFFF, 16'h8000, 8'hA5}, 1'b0, none});
        rows.push_back('{'{17'd131071, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b0, none});
        rows.push_back('{'{17'd32768, 16'd32768, 16'd0, 8'd1}, 1'b0, none});
        rows.push_back('{'{17'd32768, 16'd32768, 16'd16384, 8'd2}, 1'b0, none});
        rows.push_back('{'{17'd32768, 16'd32768, 16'd32768, 8'd4}, 1'b0, none});
        rows.push_back('{'{17'd32768, 16'd32768, 16'd49152, 8'd8}, 1'b0, none});
        rows.push_back('{'{17'd45000, 16'd8000, 16'd8192, 8'd16}, 1'b0, none});
        rows.push_back('{'{17'd60000, 16'd4000, 16'd40000, 8'd32}, 1'b0, none});
        rows.push_back('{'{17'd200, 16'd100, 16'd3000, 8'd64}, 1'b0, none});
        rows.push_back('{'{17'd3000, 16'd500, 16'd20000, 8'd128}, 1'b0, none});
        rows.push_back('{'{17'd65535, 16'd1, 16'd1, 8'd127}, 1'b0, none});
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_colour(rows[i].c, rows[i].known, rows[i].px);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            // hold off once until the pipeline has drained
            if (n == N_RANDOM / 2)
            begin
                s_axis_tvalid <= 1'b0;
                while (pixel_q.size() != 0) @(posedge clk);
            end
            c = rand_colour();
            send_colour(c, 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // Output side: random stalls and in-order comparison
    initial
    begin
        rgba_t got;
        rgba_t want;
        int    stall;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        stall         = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                       m_axis_tdata[31:24]};
                if (pixel_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: %h", got);
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected r=%0d g=%0d b=%0d a=%0d, ",
                                      "got r=%0d g=%0d b=%0d a=%0d"},
                                     want.red, want.green, want.blue, want.opacity_out,
                                     got.red, got.green, got.blue, got.opacity_out);
                    end
                end
                stall = $urandom_range(0, 14);
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // End of run
    initial
    begin
        wait (sending_done);
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (1000) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Timeout
    initial
    begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
